// ===== src/cbmopi_pkg.sv =====
// ----------------------------------------------------------------------------
// cbmopi_pkg
// shared widths and defaults for the base -1+i codec
// ----------------------------------------------------------------------------
package cbmopi_pkg;

    localparam int DIGITS_DEF = 64;
    localparam int DIGITS_MAX = 64;
    localparam int PART_W     = 36;
    localparam int WORK_W     = PART_W + 2;
    localparam int TDATA_W    = 2 * PART_W + DIGITS_MAX;

    typedef enum logic
    {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

endpackage

// ===== src/complex_base_minus_one_plus_i_codec.sv =====
// ----------------------------------------------------------------------------
// complex_base_minus_one_plus_i_codec
// digit-serial converter between gaussian integers and base -1+i digit words
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request per transaction, tuser selects the operation:
//   encode turns real_in + i*imag_in into a DIGITS-digit word, decode turns
//   digits_in back into real and imaginary parts
//   m_axis returns one result per request; fields of the other operation
//   are zero
// serial datapath
//   one digit is produced or consumed per cycle by the serial datapath; a
//   request runs through all of its digits and then the done state before
//   m_axis_tvalid, and no new request is taken until the sequencer is idle
// reset
//   rst_n clears the sequencer and the output valid; no request is pending
// stall
//   a finished result waits in the output register; the next request is
//   accepted and worked on meanwhile, and a second finished result waits in
//   the datapath until the output register is free
// ----------------------------------------------------------------------------
module complex_base_minus_one_plus_i_codec
    import cbmopi_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // real_in[35:0], imag_in[71:36], digits_in[135:72]
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // operation[0]
    input  logic               s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // digits_out[63:0], real_out[99:64], imag_out[135:100]
    output logic [TDATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(DIGITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    op_t                        op_reg, op_next;
    logic signed [WORK_W-1:0]   re_reg, re_next;
    logic signed [WORK_W-1:0]   im_reg, im_next;
    logic signed [PART_W-1:0]   pr_reg, pr_next;
    logic signed [PART_W-1:0]   pi_reg, pi_next;
    logic signed [PART_W-1:0]   sr_reg, sr_next;
    logic signed [PART_W-1:0]   si_reg, si_next;
    logic [DIGITS-1:0]          word_reg, word_next;
    logic                       out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]         out_data_reg, out_data_next;

    logic                       in_accept;
    logic                       digit;
    logic signed [WORK_W-1:0]   re_adj;
    logic signed [WORK_W-1:0]   nr_full;
    logic signed [WORK_W-1:0]   ni_full;
    logic [PART_W-1:0]          real_res;
    logic [PART_W-1:0]          imag_res;
    logic [DIGITS_MAX-1:0]      digits_res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // encode step: digit, subtract it, multiply by -1-i
    assign digit   = re_reg[0] ^ im_reg[0];
    assign re_adj  = re_reg - WORK_W'(digit);
    assign nr_full = im_reg - re_adj;
    assign ni_full = -re_adj - im_reg;

    assign real_res   = (op_reg == OP_DECODE) ? sr_reg : '0;
    assign imag_res   = (op_reg == OP_DECODE) ? si_reg : '0;
    assign digits_res = (op_reg == OP_ENCODE) ? DIGITS_MAX'(word_reg) : '0;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        re_next        = re_reg;
        im_next        = im_reg;
        pr_next        = pr_reg;
        pi_next        = pi_reg;
        sr_next        = sr_reg;
        si_next        = si_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next  = op_t'(s_axis_tuser);
                    re_next  = WORK_W'(signed'(s_axis_tdata[PART_W-1:0]));
                    im_next  = WORK_W'(signed'(s_axis_tdata[2*PART_W-1:PART_W]));
                    pr_next  = PART_W'(1);
                    pi_next  = '0;
                    sr_next  = '0;
                    si_next  = '0;
                    cnt_next = '0;
                    if (op_t'(s_axis_tuser) == OP_DECODE)
                    begin
                        word_next = s_axis_tdata[2*PART_W +: DIGITS];
                    end
                    else
                    begin
                        word_next = '0;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (op_reg == OP_ENCODE)
                begin
                    re_next   = nr_full >>> 1;
                    im_next   = ni_full >>> 1;
                    word_next = {digit, word_reg[DIGITS-1:1]};
                end
                else
                begin
                    if (word_reg[0])
                    begin
                        sr_next = sr_reg + pr_reg;
                        si_next = si_reg + pi_reg;
                    end
                    // next place value: multiply by -1+i
                    pr_next   = -pr_reg - pi_reg;
                    pi_next   = pr_reg - pi_reg;
                    word_next = {1'b0, word_reg[DIGITS-1:1]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {imag_res, real_res, digits_res};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            op_reg        <= OP_ENCODE;
            re_reg        <= '0;
            im_reg        <= '0;
            pr_reg        <= '0;
            pi_reg        <= '0;
            sr_reg        <= '0;
            si_reg        <= '0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            re_reg        <= re_next;
            im_reg        <= im_next;
            pr_reg        <= pr_next;
            pi_reg        <= pi_next;
            sr_reg        <= sr_next;
            si_reg        <= si_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

`ifndef SYNTH
    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_RUN) && (cnt_reg == '0))
        else $error("request not started");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && (cnt_reg == CNT_LAST) |=> (state_reg == ST_DONE))
        else $error("digit count overrun");

    a_exact_half: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && (op_reg == OP_ENCODE) |-> !nr_full[0] && !ni_full[0])
        else $error("inexact halving in encode step");

    a_fields_split: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[DIGITS_MAX-1:0] != '0)
            |-> (m_axis_tdata[TDATA_W-1:DIGITS_MAX] == '0))
        else $error("encode result carries decoded parts");

    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && !m_axis_tvalid |=> m_axis_tvalid && (state_reg == ST_IDLE))
        else $error("finished result not handed to output");
`endif

endmodule

// ===== dv/tb_complex_base_minus_one_plus_i_codec.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_base_minus_one_plus_i_codec
// self-checking bench for the base -1+i encoder and decoder
// ----------------------------------------------------------------------------
// A table of hand-picked requests (zero, unit values, field extremes, long
// expansions, ignored fields) is sent first. About eleven hundred random
// encode and decode requests follow in three pacing phases. Every result is
// checked field by field against a value from the table or a digit-serial
// model of the conversion kept in the bench. One long output stall fills
// the block and backs up its input.
// ----------------------------------------------------------------------------
module tb_complex_base_minus_one_plus_i_codec;
    import cbmopi_pkg::*;

    localparam int          RANDOM_PER_PHASE = 360;
    localparam int          HOLD_CYCLES      = 1000;
    localparam int          DRAIN_CYCLES     = 2 * (DIGITS_DEF + 2);
    localparam int unsigned CYCLE_LIMIT      = 600000;

    localparam logic [PART_W-1:0]     PART_MAX  = {1'b0, {(PART_W - 1){1'b1}}};
    localparam logic [PART_W-1:0]     PART_MIN  = {1'b1, {(PART_W - 1){1'b0}}};
    localparam logic [PART_W-1:0]     PART_NEG1 = {PART_W{1'b1}};
    localparam logic [PART_W-1:0]     PART_NEG2 = {{(PART_W - 1){1'b1}}, 1'b0};
    localparam logic [DIGITS_MAX-1:0] WORD_ONES = {DIGITS_MAX{1'b1}};

    typedef struct packed {
        logic [DIGITS_MAX-1:0] digits;
        logic [PART_W-1:0]     re;
        logic [PART_W-1:0]     im;
    } codec_result_t;

    typedef struct packed {
        op_t                   op;
        logic [PART_W-1:0]     re;
        logic [PART_W-1:0]     im;
        logic [DIGITS_MAX-1:0] digits;
        logic                  has_value;
        codec_result_t         result;
    } stim_row_t;

    localparam int DIRECTED_N = 22;

    stim_row_t directed_rows [DIRECTED_N] = '{
        '{OP_ENCODE, 36'd0, 36'd0, 64'd0, 1'b1, '{64'd0, 36'd0, 36'd0}},
        '{OP_ENCODE, 36'd1, 36'd0, 64'd0, 1'b1, '{64'd1, 36'd0, 36'd0}},
        '{OP_ENCODE, 36'd0, 36'd1, 64'd0, 1'b1, '{64'd3, 36'd0, 36'd0}},
        '{OP_ENCODE, PART_NEG1, 36'd1, 64'd0, 1'b1, '{64'd2, 36'd0, 36'd0}},
        '{OP_ENCODE, PART_MAX, PART_MAX, 64'd0, 1'b0, '0},
        '{OP_ENCODE, PART_MIN, PART_MIN, WORD_ONES, 1'b0, '0},
        '{OP_ENCODE, PART_MAX, PART_MIN, 64'd0, 1'b0, '0},
        '{OP_ENCODE, PART_MIN, PART_MAX, 64'd0, 1'b0, '0},
        '{OP_ENCODE, PART_NEG1, PART_NEG1, 64'd0, 1'b0, '0},
        '{OP_ENCODE, 36'd0, PART_MIN, 64'd0, 1'b0, '0},
        '{OP_ENCODE, PART_MAX, 36'd0, WORD_ONES, 1'b0, '0},
        '{OP_ENCODE, 36'd5, 36'hF_FFFF_FFFD, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, '0},
        '{OP_DECODE, 36'd0, 36'd0, 64'd0, 1'b1, '{64'd0, 36'd0, 36'd0}},
        '{OP_DECODE, PART_NEG1, PART_NEG1, 64'd1, 1'b1, '{64'd0, 36'd1, 36'd0}},
        '{OP_DECODE, 36'd0, 36'd0, 64'd2, 1'b1, '{64'd0, PART_NEG1, 36'd1}},
        '{OP_DECODE, 36'd0, 36'd0, 64'd3, 1'b1, '{64'd0, 36'd0, 36'd1}},
        '{OP_DECODE, 36'd0, 36'd0, 64'd4, 1'b1, '{64'd0, 36'd0, PART_NEG2}},
        '{OP_DECODE, 36'd0, 36'd0, WORD_ONES, 1'b0, '0},
        '{OP_DECODE, 36'd0, 36'd0, 64'h8000_0000_0000_0000, 1'b0, '0},
        '{OP_DECODE, PART_MAX, PART_MIN, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{OP_DECODE, 36'd0, 36'd0, 64'h5555_5555_5555_5555, 1'b0, '0},
        '{OP_DECODE, 36'd0, 36'd0, 64'h0123_4567_89AB_CDEF, 1'b0, '0}
    };

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;
    logic               s_axis_tuser  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;

    codec_result_t conversion_q [$];
    int            error_count  = 0;
    int            tx_idle_pct  = 13;
    int            rx_idle_pct  = 63;
    int            phase_no     = 0;

    complex_base_minus_one_plus_i_codec uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // digit-serial conversion, one digit per step
    function automatic codec_result_t convert_gaussian(input op_t op,
                                                       input logic [PART_W-1:0] re_in,
                                                       input logic [PART_W-1:0] im_in,
                                                       input logic [DIGITS_MAX-1:0] word);
        codec_result_t res;
        longint        re;
        longint        im;
        longint        nr;
        longint        pr;
        longint        pi;
        longint        sr;
        longint        si;
        int            k;
        res = '0;
        if (op == OP_ENCODE)
        begin
            re = longint'($signed(re_in));
            im = longint'($signed(im_in));
            for (k = 0; k < DIGITS_DEF; k++)
            begin
                if (re == 0 && im == 0)
                    break;
                if (re[0] ^ im[0])
                begin
                    res.digits[k] = 1'b1;
                    re = re - 1;
                end
                // times -1-i, both parts even so the halving is exact
                nr = im - re;
                im = (-re - im) >>> 1;
                re = nr >>> 1;
            end
        end
        else
        begin
            pr = 1;
            pi = 0;
            sr = 0;
            si = 0;
            for (k = 0; k < DIGITS_DEF; k++)
            begin
                if (word[k])
                begin
                    sr = sr + pr;
                    si = si + pi;
                end
                // next place value, times -1+i
                nr = -pr - pi;
                pi = pr - pi;
                pr = nr;
            end
            res.re = sr[PART_W-1:0];
            res.im = si[PART_W-1:0];
        end
        return res;
    endfunction

    task automatic draw_request(output op_t op,
                                output logic [PART_W-1:0] re,
                                output logic [PART_W-1:0] im,
                                output logic [DIGITS_MAX-1:0] dg);
        longint span;
        int     pick;
        pick = $urandom_range(0, 9);
        re   = PART_W'({$urandom(), $urandom()});
        im   = PART_W'({$urandom(), $urandom()});
        dg   = {$urandom(), $urandom()};
        op   = OP_ENCODE;
        case (pick)
            4:
            begin
                span = longint'($urandom_range(0, 4000)) - 2000;
                re   = span[PART_W-1:0];
                span = longint'($urandom_range(0, 4000)) - 2000;
                im   = span[PART_W-1:0];
            end
            5:
            begin
                re = ($urandom_range(0, 1) ? PART_MAX : PART_MIN) ^ PART_W'($urandom_range(0, 15));
                im = ($urandom_range(0, 1) ? PART_MAX : PART_MIN) ^ PART_W'($urandom_range(0, 15));
            end
            6, 7, 8:
                op = OP_DECODE;
            9:
            begin
                op = OP_DECODE;
                dg = dg & {$urandom(), $urandom()} & {$urandom(), $urandom()};
            end
            default:
                op = OP_ENCODE;
        endcase
    endtask

    // entered and left at a falling edge
    task automatic offer_request(input op_t op,
                                 input logic [PART_W-1:0] re,
                                 input logic [PART_W-1:0] im,
                                 input logic [DIGITS_MAX-1:0] dg,
                                 input codec_result_t expected);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {dg, im, re};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        conversion_q.push_back(expected);
        @(negedge clk);
    endtask

    initial
    begin : request_source
        op_t                   op;
        logic [PART_W-1:0]     re;
        logic [PART_W-1:0]     im;
        logic [DIGITS_MAX-1:0] dg;
        stim_row_t             row;
        @(posedge rst_n);
        @(negedge clk);
        for (int i = 0; i < DIRECTED_N; i++)
        begin
            row = directed_rows[i];
            offer_request(row.op, row.re, row.im, row.digits,
                          row.has_value ? row.result
                                        : convert_gaussian(row.op, row.re, row.im, row.digits));
        end
        for (int p = 0; p < 3; p++)
        begin
            phase_no    = p;
            tx_idle_pct = (p == 0) ? 13 : (p == 1) ? 63 : 0;
            rx_idle_pct = (p == 0) ? 63 : (p == 1) ? 13 : 0;
            repeat (RANDOM_PER_PHASE)
            begin
                draw_request(op, re, im, dg);
                offer_request(op, re, im, dg, convert_gaussian(op, re, im, dg));
            end
        end
        s_axis_tvalid <= 1'b0;
        while (conversion_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_complex_base_minus_one_plus_i_codec passed");
        else
            $display("tb_complex_base_minus_one_plus_i_codec failed");
        $finish;
    end

    // long output stall once the unpaced phase begins
    initial
    begin : result_sink
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (phase_no == 2 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        codec_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (conversion_q.size() == 0)
            begin
                $error("result transaction with none pending, tdata %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = conversion_q.pop_front();
                if (m_axis_tdata[DIGITS_MAX-1:0] !== want.digits)
                begin
                    $error("digits_out expected %h actual %h",
                           want.digits, m_axis_tdata[DIGITS_MAX-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[DIGITS_MAX +: PART_W] !== want.re)
                begin
                    $error("real_out expected %h actual %h",
                           want.re, m_axis_tdata[DIGITS_MAX +: PART_W]);
                    error_count++;
                end
                if (m_axis_tdata[DIGITS_MAX + PART_W +: PART_W] !== want.im)
                begin
                    $error("imag_out expected %h actual %h",
                           want.im, m_axis_tdata[DIGITS_MAX + PART_W +: PART_W]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles_run;
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("tb_complex_base_minus_one_plus_i_codec failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/cbmopi_pkg.sv
src/complex_base_minus_one_plus_i_codec.sv
dv/tb_complex_base_minus_one_plus_i_codec.sv
